/* sv/trackball_peak_inertia_unit_defines.svh */
// Assertion macros shared by the checker of the trackball glide block.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef TRACKBALL_PEAK_INERTIA_UNIT_DEFINES_SVH
`define TRACKBALL_PEAK_INERTIA_UNIT_DEFINES_SVH

// Property checked outside reset
`define TPI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked during reset as well
`define TPI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/tpi_pkg.sv */
// Shared types, command codes and constants of the trackball glide block.
// Used by the controller, the datapath and the top level.
package tpi_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 8;

  // Datapath commands
  typedef logic [3:0] cmd_t;
  localparam cmd_t CMD_NONE = 4'd0;
  localparam cmd_t CMD_LOAD = 4'd1;
  localparam cmd_t CMD_CLR  = 4'd2;
  localparam cmd_t CMD_AVG  = 4'd3;
  localparam cmd_t CMD_FS   = 4'd4;
  localparam cmd_t CMD_FX   = 4'd5;
  localparam cmd_t CMD_FY   = 4'd6;
  localparam cmd_t CMD_PATH = 4'd7;
  localparam cmd_t CMD_KX   = 4'd8;
  localparam cmd_t CMD_KY   = 4'd9;
  localparam cmd_t CMD_DX   = 4'd10;
  localparam cmd_t CMD_DY   = 4'd11;
  localparam cmd_t CMD_FIN  = 4'd12;
  localparam cmd_t CMD_EMIT = 4'd13;

  // Status from datapath to controller
  typedef struct packed {
    logic key;
    logic btn;
    logic moving;
    logic coast;
    logic forget;
    logic glide_ok;
    logic out_free;
  } stat_t;

  // Action codes
  localparam logic [1:0] ACT_FRAME  = 2'd0;
  localparam logic [1:0] ACT_KEY    = 2'd1;
  localparam logic [1:0] ACT_TOGGLE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PTR_PEAK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PTR_KICK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PTR_DECAY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCR_PEAK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCR_KICK  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCR_DECAY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd6;

  // Register reset values
  localparam logic [7:0] RST_PTR_PEAK  = 8'd6;
  localparam logic [7:0] RST_PTR_KICK  = 8'd140;
  localparam logic [7:0] RST_PTR_DECAY = 8'd240;
  localparam logic [7:0] RST_SCR_PEAK  = 8'd25;
  localparam logic [7:0] RST_SCR_KICK  = 8'd220;
  localparam logic [7:0] RST_SCR_DECAY = 8'd249;

  localparam logic [7:0] PEAK_FORGET = 8'd252;
  localparam logic [7:0] DECAY_MAX   = 8'd254;
  localparam logic [7:0] DECAY_FULL  = 8'd255;

endpackage

/* sv/trackball_peak_inertia_unit.sv */
// Trackball glide block: top level joining the sequencer and the datapath.
// Depends on tpi_pkg, tpi_ctrl and tpi_datapath.
//
// Usage:
//  - in_*: one request per handshake, a sensor frame or a key event (tuser).
//  - out_*: exactly one result per request, in request order.
//  - cfg_*: register writes, accepted every cycle; write only while idle.
//  - Path: key events and button frames take the short path from acceptance
//    to the result register, a scroll frame that starts a glide takes the
//    long one. The long path is set by the
//    single shared multiplier (velocity times an 8-bit factor), one product
//    per cycle, up to seven products per frame.
//  - Throughput: one request in flight; in_tready is high only while the
//    sequencer is idle, so the next request waits until the result is loaded.
//  - Stall: a result waits in the output register while out_tready is low;
//    the next request is still accepted and stops before its result load.
//  - Reset (rst_n low, synchronous): trackers cleared, registers at their
//    defaults, no result pending.
module trackball_peak_inertia_unit #(
  parameter int FRAC_BITS = tpi_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,  // move_x, move_y, scroll_h, scroll_v
  input  logic [3:0]                      in_tuser,  // action[1:0], scroll_mode, buttons_held
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [31:0]                     out_tdata, // out_x, out_y, out_h, out_v
  output logic [0:0]                      out_tuser, // gliding
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tpi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tpi_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tpi_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  tpi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tpi_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

endmodule

/* sv/tpi_ctrl.sv */
// Sequencer of the trackball glide block: steps the datapath through one request.
// Depends on tpi_pkg.
module tpi_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  tpi_pkg::stat_t stat,
  output tpi_pkg::cmd_t  cmd
);
  import tpi_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_AVG  = 4'd2;
  localparam logic [3:0] S_FS   = 4'd3;
  localparam logic [3:0] S_FX   = 4'd4;
  localparam logic [3:0] S_FY   = 4'd5;
  localparam logic [3:0] S_PATH = 4'd6;
  localparam logic [3:0] S_KX   = 4'd7;
  localparam logic [3:0] S_KY   = 4'd8;
  localparam logic [3:0] S_DX   = 4'd9;
  localparam logic [3:0] S_DY   = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;
  localparam logic [3:0] S_EMIT = 4'd12;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Pick the command and the next step
  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_CLR;
        end
      end
      S_CLR: begin
        cmd       = CMD_CLR;
        state_nxt = (stat.key || stat.btn) ? S_EMIT : S_AVG;
      end
      S_AVG: begin
        cmd       = CMD_AVG;
        state_nxt = stat.forget ? S_FS : S_PATH;
      end
      S_FS: begin
        cmd       = CMD_FS;
        state_nxt = S_FX;
      end
      S_FX: begin
        cmd       = CMD_FX;
        state_nxt = S_FY;
      end
      S_FY: begin
        cmd       = CMD_FY;
        state_nxt = S_PATH;
      end
      S_PATH: begin
        cmd = CMD_PATH;
        if (stat.moving) begin
          state_nxt = S_EMIT;
        end else if (stat.coast) begin
          state_nxt = S_DX;
        end else if (stat.glide_ok) begin
          state_nxt = S_KX;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_KX: begin
        cmd       = CMD_KX;
        state_nxt = S_KY;
      end
      S_KY: begin
        cmd       = CMD_KY;
        state_nxt = S_DX;
      end
      S_DX: begin
        cmd       = CMD_DX;
        state_nxt = S_DY;
      end
      S_DY: begin
        cmd       = CMD_DY;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd       = CMD_FIN;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd       = CMD_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/tpi_datapath.sv */
// Datapath of the trackball glide block: trackers, config registers, shared
// multiplier and output register. Depends on tpi_pkg.
module tpi_datapath #(
  parameter int FRAC_BITS = tpi_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tpi_pkg::cmd_t                   cmd,
  output tpi_pkg::stat_t                  stat,
  input  logic [31:0]                     in_tdata,
  input  logic [3:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [31:0]                     out_tdata,
  output logic [0:0]                      out_tuser,
  input  logic                            cfg_valid,
  input  logic [tpi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tpi_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tpi_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int VW  = F + 10;
  localparam int VW1 = VW + 1;
  localparam int SW  = VW + 4;
  localparam int PW  = VW + 9;
  localparam int TW  = VW + 8;
  localparam int QW  = VW1 - F;

  // Tracker state, index 0 pointer, index 1 scroll
  logic signed [VW-1:0] vx_r [2];
  logic signed [VW-1:0] vy_r [2];
  logic signed [VW-1:0] pvx_r [2];
  logic signed [VW-1:0] pvy_r [2];
  logic [VW-1:0]        pk_r [2];
  logic [F-1:0]         rx_r [2];
  logic [F-1:0]         ry_r [2];
  logic [1:0]           cst_r;
  logic                 prev_r;
  logic                 flip_r;

  // Config registers
  logic [7:0] ppk_r, pkick_r, pdec_r, spk_r, skick_r, sdec_r;
  logic       en_r;

  // Latched request and working result
  logic [1:0]        act_r;
  logic              scr_r, btn_r;
  logic signed [7:0] mx_r, my_r, sh_r, sv_r;
  logic [7:0]        res_x_r, res_y_r, res_h_r, res_v_r;
  logic              res_gl_r;

  // Output register
  logic        out_vld_r;
  logic [31:0] out_data_r;
  logic        out_gl_r;

  function automatic logic [VW:0] absv(input logic signed [VW-1:0] v);
    logic signed [VW:0] w;
    w = VW1'(v);
    absv = w[VW] ? -w : w;
  endfunction

  logic                 t;
  logic signed [VW-1:0] cvx, cvy;
  logic                 ptr_mov, scr_mov, moving, upd;
  logic signed [VW:0]   px, py, ptx, pty;
  logic signed [SW-1:0] qsx, qsy, qtx, qty;
  logic signed [VW-1:0] nvx, nvy;
  logic [VW:0]          nmag, vmag, ptr_thr, stop_thr;
  logic                 bigger, below, stopped;
  logic [TW-1:0]        pk100, scr_thr;
  logic signed [VW-1:0] mul_a;
  logic [7:0]           mul_b;
  logic signed [PW-1:0] prod;
  logic signed [VW-1:0] mres;
  logic signed [VW:0]   rsx, rsy;
  logic signed [QW-1:0] qx, qy;
  logic [7:0]           cx, cy;
  logic                 key_clr, frame_clr, p_clr, path_clr, fin_clr, cfg_clr;
  logic [1:0]           clr;

  assign t   = scr_r;
  assign cvx = vx_r[t];
  assign cvy = vy_r[t];

  assign ptr_mov = (mx_r != 8'sd0) || (my_r != 8'sd0);
  assign scr_mov = (sh_r != 8'sd0) || (sv_r != 8'sd0);
  assign moving  = scr_r ? scr_mov : ptr_mov;
  assign upd     = scr_r ? !cst_r[1] : ptr_mov;

  // Velocity averaging: pointer by halves, scroll by 15/16, truncating toward zero
  always_comb begin
    px  = VW1'(cvx) + (VW1'(mx_r) <<< F);
    py  = VW1'(cvy) + (VW1'(my_r) <<< F);
    ptx = (px + (px[VW] ? VW1'(1) : VW1'(0))) >>> 1;
    pty = (py + (py[VW] ? VW1'(1) : VW1'(0))) >>> 1;
    qsx = (SW'(cvx) <<< 4) - SW'(cvx) + (SW'(sh_r) <<< F);
    qsy = (SW'(cvy) <<< 4) - SW'(cvy) + (SW'(sv_r) <<< F);
    qtx = (qsx + (qsx[SW-1] ? SW'(15) : SW'(0))) >>> 4;
    qty = (qsy + (qsy[SW-1] ? SW'(15) : SW'(0))) >>> 4;
    if (scr_r) begin
      nvx = qtx[VW-1:0];
      nvy = qty[VW-1:0];
    end else begin
      nvx = ptx[VW-1:0];
      nvy = pty[VW-1:0];
    end
  end

  assign nmag   = absv(nvx) + absv(nvy);
  assign bigger = nmag > VW1'(pk_r[t]);

  // Glide start threshold; scroll threshold is the register in 1/100 step, floored
  assign ptr_thr = VW1'(ppk_r) << F;
  assign pk100   = (TW'(pk_r[t]) << 6) + (TW'(pk_r[t]) << 5) + (TW'(pk_r[t]) << 2);
  assign scr_thr = TW'(spk_r) << F;
  assign below   = scr_r ? ((pk100 + TW'(100)) <= scr_thr) : (VW1'(pk_r[t]) < ptr_thr);

  // Shared multiplier, scaled back by 1/256 with floor
  always_comb begin
    mul_a = cvx;
    mul_b = PEAK_FORGET;
    case (cmd)
      CMD_FS: mul_a = $signed(pk_r[t]);
      CMD_FX: mul_a = pvx_r[t];
      CMD_FY: mul_a = pvy_r[t];
      CMD_KX: begin
        mul_a = pvx_r[t];
        mul_b = scr_r ? skick_r : pkick_r;
      end
      CMD_KY: begin
        mul_a = pvy_r[t];
        mul_b = scr_r ? skick_r : pkick_r;
      end
      CMD_DX: begin
        mul_a = cvx;
        mul_b = scr_r ? sdec_r : pdec_r;
      end
      CMD_DY: begin
        mul_a = cvy;
        mul_b = scr_r ? sdec_r : pdec_r;
      end
      default: begin
        mul_a = cvx;
      end
    endcase
  end

  assign prod = PW'(mul_a) * PW'($signed({1'b0, mul_b}));
  assign mres = prod[VW+7:8];

  // Glide position step and stop test
  assign vmag     = absv(cvx) + absv(cvy);
  assign stop_thr = scr_r ? (VW1'(1) << (F - 4)) : (VW1'(1) << (F - 1));
  assign stopped  = vmag < stop_thr;
  assign rsx      = $signed(VW1'(rx_r[t])) + VW1'(cvx);
  assign rsy      = $signed(VW1'(ry_r[t])) + VW1'(cvy);
  assign qx       = rsx[VW:F];
  assign qy       = rsy[VW:F];

  always_comb begin
    cx = qx[7:0];
    cy = qy[7:0];
    if (qx > QW'(127)) cx = 8'sd127;
    if (qx < QW'(-127)) cx = -8'sd127;
    if (qy > QW'(127)) cy = 8'sd127;
    if (qy < QW'(-127)) cy = -8'sd127;
  end

  // Tracker clears
  assign key_clr   = (cmd == CMD_CLR) && ((act_r == ACT_KEY) || (act_r == ACT_TOGGLE));
  assign frame_clr = (cmd == CMD_CLR) && (act_r == ACT_FRAME) &&
                     ((scr_r != prev_r) || btn_r);
  assign p_clr     = (cmd == CMD_CLR) && (act_r == ACT_FRAME) && !scr_r && ptr_mov &&
                     cst_r[0];
  assign path_clr  = (cmd == CMD_PATH) && !moving && !cst_r[t] &&
                     !((en_r ^ flip_r) && !below);
  assign fin_clr   = (cmd == CMD_FIN) && stopped;
  assign cfg_clr   = cfg_valid && (cfg_index <= REG_ENABLE);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      clr[i] = key_clr || frame_clr || cfg_clr ||
               ((path_clr || fin_clr) && (t == i[0])) || (p_clr && (i == 0));
    end
  end

  // Status to controller
  assign stat.key      = (act_r != ACT_FRAME);
  assign stat.btn      = btn_r;
  assign stat.moving   = moving;
  assign stat.coast    = cst_r[t];
  assign stat.forget   = upd && !bigger;
  assign stat.glide_ok = (en_r ^ flip_r) && !below;
  assign stat.out_free = !out_vld_r || out_tready;

  // Tracker and mode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        vx_r[i]  <= '0;
        vy_r[i]  <= '0;
        pvx_r[i] <= '0;
        pvy_r[i] <= '0;
        pk_r[i]  <= '0;
        rx_r[i]  <= '0;
        ry_r[i]  <= '0;
      end
      cst_r  <= '0;
      prev_r <= 1'b0;
      flip_r <= 1'b0;
    end else begin
      case (cmd)
        CMD_CLR: begin
          if (act_r == ACT_TOGGLE) flip_r <= !flip_r;
          if (act_r == ACT_FRAME) prev_r <= scr_r;
        end
        CMD_AVG: begin
          if (upd) begin
            vx_r[t] <= nvx;
            vy_r[t] <= nvy;
            if (bigger) begin
              pk_r[t]  <= nmag[VW-1:0];
              pvx_r[t] <= nvx;
              pvy_r[t] <= nvy;
            end
          end
        end
        CMD_FS: pk_r[t]  <= mres;
        CMD_FX: pvx_r[t] <= mres;
        CMD_FY: pvy_r[t] <= mres;
        CMD_PATH: begin
          if (moving) begin
            cst_r[t] <= 1'b0;
            rx_r[t]  <= '0;
            ry_r[t]  <= '0;
          end
        end
        CMD_KX: vx_r[t] <= mres;
        CMD_KY: begin
          vy_r[t]  <= mres;
          pk_r[t]  <= '0;
          pvx_r[t] <= '0;
          pvy_r[t] <= '0;
          rx_r[t]  <= '0;
          ry_r[t]  <= '0;
          cst_r[t] <= 1'b1;
        end
        CMD_DX: vx_r[t] <= mres;
        CMD_DY: vy_r[t] <= mres;
        CMD_FIN: begin
          rx_r[t] <= rsx[F-1:0];
          ry_r[t] <= rsy[F-1:0];
        end
        default: begin
        end
      endcase
      if (cfg_valid && (cfg_index == REG_ENABLE)) flip_r <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        if (clr[i]) begin
          vx_r[i]  <= '0;
          vy_r[i]  <= '0;
          pvx_r[i] <= '0;
          pvy_r[i] <= '0;
          pk_r[i]  <= '0;
          rx_r[i]  <= '0;
          ry_r[i]  <= '0;
          cst_r[i] <= 1'b0;
        end
      end
    end
  end

  // Config registers: zero leaves a threshold or factor unchanged
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppk_r   <= RST_PTR_PEAK;
      pkick_r <= RST_PTR_KICK;
      pdec_r  <= RST_PTR_DECAY;
      spk_r   <= RST_SCR_PEAK;
      skick_r <= RST_SCR_KICK;
      sdec_r  <= RST_SCR_DECAY;
      en_r    <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PTR_PEAK:  if (cfg_data != 8'd0) ppk_r <= cfg_data;
        REG_PTR_KICK:  if (cfg_data != 8'd0) pkick_r <= cfg_data;
        REG_PTR_DECAY: if (cfg_data != 8'd0) begin
          pdec_r <= (cfg_data == DECAY_FULL) ? DECAY_MAX : cfg_data;
        end
        REG_SCR_PEAK:  if (cfg_data != 8'd0) spk_r <= cfg_data;
        REG_SCR_KICK:  if (cfg_data != 8'd0) skick_r <= cfg_data;
        REG_SCR_DECAY: if (cfg_data != 8'd0) begin
          sdec_r <= (cfg_data == DECAY_FULL) ? DECAY_MAX : cfg_data;
        end
        REG_ENABLE:    en_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Request latch and working result
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        act_r    <= in_tuser[1:0];
        scr_r    <= in_tuser[2];
        btn_r    <= in_tuser[3];
        mx_r     <= in_tdata[7:0];
        my_r     <= in_tdata[15:8];
        sh_r     <= in_tdata[23:16];
        sv_r     <= in_tdata[31:24];
        res_x_r  <= in_tdata[7:0];
        res_y_r  <= in_tdata[15:8];
        res_h_r  <= in_tdata[23:16];
        res_v_r  <= in_tdata[31:24];
        res_gl_r <= 1'b0;
      end
      CMD_CLR: begin
        if (act_r != ACT_FRAME) begin
          res_x_r <= '0;
          res_y_r <= '0;
          res_h_r <= '0;
          res_v_r <= '0;
        end
      end
      CMD_FIN: begin
        if (!stopped) begin
          res_gl_r <= 1'b1;
          if (scr_r) begin
            res_h_r <= cx;
            res_v_r <= cy;
          end else begin
            res_x_r <= cx;
            res_y_r <= cy;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd == CMD_EMIT) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_EMIT) begin
      out_data_r <= {res_v_r, res_h_r, res_y_r, res_x_r};
      out_gl_r   <= res_gl_r;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_gl_r;

endmodule

/* sv/tpi_checker.sv */
// Port-level checks of the trackball glide block, bound to the top level.
// Depends on trackball_peak_inertia_unit_defines.svh.
`include "trackball_peak_inertia_unit_defines.svh"

module tpi_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [31:0]                     out_tdata,
  input logic [0:0]                      out_tuser
);

  // A stalled result holds
  `TPI_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)), "result changed while stalled")

  // One request at a time: no new request right after one is taken
  `TPI_ASSERT(a_one_req, (in_tvalid && in_tready) |=> !in_tready, "request taken while busy")

  // A result never appears in the cycle right after its request
  `TPI_ASSERT(a_no_early, (in_tvalid && in_tready) |=> !$rose(out_tvalid), "result too early")

  // Reset drops any pending result
  `TPI_ASSERT_RST(a_rst_out, !rst_n |=> !out_tvalid, "result pending after reset")

endmodule

bind trackball_peak_inertia_unit tpi_checker u_tpi_checker (.*);
